>>> src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// types, codes and default sizes shared by the block allocator files
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MaxBlocksDef   = 64;
	localparam int MinBlockDef    = 32;
	localparam int AlignDef       = 16;
	localparam int HeaderBytesDef = 16;

	localparam logic [1:0] FUNC_INIT    = 2'd0;
	localparam logic [1:0] FUNC_ALLOC   = 2'd1;
	localparam logic [1:0] FUNC_FREE    = 2'd2;
	localparam logic [1:0] FUNC_REALLOC = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_ARG  = 2'd2;

	localparam logic CFG_REGION_BASE  = 1'b0;
	localparam logic CFG_REGION_BYTES = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] req_size;
		logic [31:0] block_address;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_status;
		logic [31:0] data_address;
	} out_word_t;

	typedef struct packed {
		logic        in_use;
		logic [31:0] size;
		logic [31:0] start;
	} entry_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_REM  = 7'b0001000,
		S_NEW  = 7'b0010000,
		S_WR1  = 7'b0100000,
		S_WR2  = 7'b1000000
	} state_t;

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/bump_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_block_allocator
// address-only first-fit heap allocator with a bump pointer fallback
// ----------------------------------------------------------------------------
// a command word is taken when start is high and busy is low; func selects
// init, allocate, free or reallocate. exactly one result word follows, shown
// for one cycle with done high; the receiver cannot stall it.
// region_base and region_bytes are written on the cfg channel (always ready)
// and take effect at the next init.
// the block table (start, size, in-use) lives in one ram with a registered
// read; lookups walk it one entry at a time, reading in S_RD and checking
// in S_CHK. carving a new block rounds up to ALIGN (a power of two) in S_REM
// and checks the charge in S_NEW. init carves one free block; allocate walks
// for a fit and else carves; free walks for the address (bad address if none);
// reallocate walks for the address, then allocates, and releases the old
// block in S_WR2 on success.
// one command at a time; the next may be taken in the cycle done is high.
// reset empties the table and clears the bump pointer and byte count.
// ----------------------------------------------------------------------------
module bump_block_allocator
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS   = MaxBlocksDef,
	parameter int MIN_BLOCK    = MinBlockDef,
	parameter int ALIGN        = AlignDef,
	parameter int HEADER_BYTES = HeaderBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    cmd,
	output logic        done,
	output out_word_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCKS);
	localparam logic [35:0]   HDR      = 36'(HEADER_BYTES);
	localparam logic [35:0]   ALN_M1   = 36'(ALIGN - 1);
	localparam logic [31:0]   ALN_M1_W = 32'(ALIGN - 1);
	localparam logic [33:0]   ALN_MSK  = ~34'(ALIGN - 1);
	localparam logic [33:0]   MIN_W    = 34'(MIN_BLOCK);

	state_t        state_q;
	logic [1:0]    func_q;
	logic [31:0]   req_q, addr_q;
	logic [CW-1:0] idx_q, cnt_q;
	logic          fit_mode_q;
	logic [31:0]   bump_q, base_q, bytes_q;
	logic [32:0]   left_q;
	logic [AW-1:0] wa_q, oa_q;
	entry_t        wd_q, od_q;
	logic [1:0]    status_q;
	logic [31:0]   data_q;
	logic [33:0]   rsrc_q, bsize_q;
	logic [31:0]   nstart_q;
	logic          done_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata, rdata;
	logic [33:0]   want;
	logic [35:0]   total;
	logic [31:0]   rd_data_addr;
	logic          hit_addr, hit_fit;

	bba_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = '{result_status: status_q, data_address: data_q};

	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = wd_q;
		if (state_q == S_WR1) begin
			we = 1'b1;
		end else if (state_q == S_WR2) begin
			we    = 1'b1;
			waddr = oa_q;
			wdata = od_q;
		end
	end

	assign want         = ({2'b0, req_q} < MIN_W) ? MIN_W : {2'b0, req_q};
	assign total        = HDR + {2'b0, bsize_q} + ALN_M1;
	assign rd_data_addr = 32'(36'(rdata.start) + HDR);
	assign hit_addr     = (rd_data_addr == addr_q);
	assign hit_fit      = !rdata.in_use && (rdata.size >= req_q)
		&& ({1'b0, rdata.size - req_q} <= 33'(MIN_BLOCK));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bump_q  <= '0;
			left_q  <= '0;
			base_q  <= '0;
			bytes_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_REGION_BASE:  base_q  <= cfg_data;
					CFG_REGION_BYTES: bytes_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q     <= cmd.func;
						req_q      <= cmd.req_size;
						addr_q     <= cmd.block_address;
						idx_q      <= '0;
						status_q   <= ST_OK;
						data_q     <= '0;
						fit_mode_q <= (cmd.func == FUNC_ALLOC);
						if (cmd.func == FUNC_INIT) begin
							cnt_q    <= '0;
							bump_q   <= base_q;
							left_q   <= {1'b0, bytes_q};
							rsrc_q   <= MIN_W + 34'(ALN_M1);
							state_q  <= S_REM;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (idx_q == cnt_q) begin
						if (fit_mode_q) begin
							rsrc_q   <= want + 34'(ALN_M1);
							state_q  <= S_REM;
						end else begin
							status_q <= ST_BAD_ARG;
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
						end
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!fit_mode_q && hit_addr) begin
						if (func_q == FUNC_FREE) begin
							wa_q    <= idx_q[AW-1:0];
							wd_q    <= '{in_use: 1'b0, size: rdata.size, start: rdata.start};
							state_q <= S_WR1;
						end else begin
							oa_q       <= idx_q[AW-1:0];
							od_q       <= '{in_use: 1'b0, size: rdata.size, start: rdata.start};
							fit_mode_q <= 1'b1;
							idx_q      <= '0;
							state_q    <= S_RD;
						end
					end else if (fit_mode_q && hit_fit) begin
						wa_q    <= idx_q[AW-1:0];
						wd_q    <= '{in_use: 1'b1, size: rdata.size, start: rdata.start};
						data_q  <= rd_data_addr;
						state_q <= S_WR1;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_REM: begin
					bsize_q  <= rsrc_q & ALN_MSK;
					nstart_q <= (bump_q + ALN_M1_W) & ALN_MSK[31:0];
					state_q  <= S_NEW;
				end
				S_NEW: begin
					if (cnt_q == CNT_MAX || total > {3'b0, left_q}) begin
						status_q <= ST_NO_SPACE;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else begin
						wa_q    <= cnt_q[AW-1:0];
						wd_q    <= '{in_use: (func_q != FUNC_INIT), size: bsize_q[31:0],
							start: nstart_q};
						cnt_q   <= cnt_q + 1'b1;
						left_q  <= left_q - total[32:0];
						bump_q  <= bump_q + total[31:0];
						if (func_q != FUNC_INIT) begin
							data_q <= 32'(36'(nstart_q) + HDR);
						end
						state_q <= S_WR1;
					end
				end
				S_WR1: begin
					if (func_q == FUNC_REALLOC) begin
						state_q <= S_WR2;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_WR2: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("block count beyond table depth");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.result_status == ST_OK || result.result_status == ST_NO_SPACE
			|| result.result_status == ST_BAD_ARG))
		else $error("bad status code");

	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.result_status != ST_OK) |-> result.data_address == 32'd0)
		else $error("data address on error");

	a_wr2_realloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR2 |-> func_q == FUNC_REALLOC)
		else $error("old block release outside reallocate");

	a_align_pow2: assert property (@(posedge clk)
		(ALIGN & (ALIGN - 1)) == 0)
		else $error("alignment is not a power of two");

endmodule

>>> tb/tb_bump_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bump_block_allocator
// self-checking bench for the first-fit block allocator
// ----------------------------------------------------------------------------
// a clocked driver issues command words from a pending queue and updates a
// local allocator model on every accepted word; a clocked monitor checks each
// result word against the oldest predicted one. the region registers are
// rewritten between phases while the block is idle, including empty, tight,
// exact-fit and wrapping regions, and one phase fills the block table.
// ----------------------------------------------------------------------------
module tb_bump_block_allocator;
	import bba_pkg::*;

	localparam int NBLK = MaxBlocksDef;
	localparam int WDOG_LIMIT = 5000;
	localparam longint MASK = 64'hFFFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_word_t    cmd = '0;
	logic        done;
	out_word_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_REGION_BASE;
	logic [31:0] cfg_data = '0;

	bump_block_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// allocator model
	logic [31:0] m_base = '0, m_bytes = '0;
	logic [31:0] m_start [NBLK];
	logic [31:0] m_size [NBLK];
	bit          m_used [NBLK];
	int          m_count = 0;
	logic [31:0] m_bump = '0;
	longint      m_left = 0;

	in_word_t    pending_q[$];
	out_word_t   result_q[$];
	logic [31:0] live_addr[$];

	int  errors = 0, n_words = 0, n_results = 0, wdog = 0;
	int  n_func[4], n_status[4];
	bit  no_gap = 1'b0;
	int  gap = 0;

	function automatic longint round_al(longint x);
		return ((x + AlignDef - 1) / AlignDef) * AlignDef;
	endfunction

	function automatic logic [31:0] data_addr(int i);
		return m_start[i] + HeaderBytesDef;
	endfunction

	function automatic int carve(longint req);
		longint want, bsz, total;
		want = (req < MinBlockDef) ? MinBlockDef : req;
		bsz = round_al(want);
		total = HeaderBytesDef + bsz + AlignDef - 1;
		if (m_count >= NBLK || total > m_left)
			return -1;
		m_start[m_count] = round_al(longint'(m_bump)) & MASK;
		m_size[m_count] = bsz;
		m_used[m_count] = 1'b0;
		m_left -= total;
		m_bump = (longint'(m_bump) + total) & MASK;
		m_count++;
		return m_count - 1;
	endfunction

	function automatic int first_fit(longint req);
		for (int i = 0; i < m_count; i++)
			if (!m_used[i] && m_size[i] >= req && m_size[i] - req <= MinBlockDef)
				return i;
		return -1;
	endfunction

	function automatic int lookup(logic [31:0] a);
		for (int i = 0; i < m_count; i++)
			if (data_addr(i) == a)
				return i;
		return -1;
	endfunction

	function automatic int grant(longint req);
		int b;
		b = first_fit(req);
		if (b < 0)
			b = carve(req);
		if (b >= 0)
			m_used[b] = 1'b1;
		return b;
	endfunction

	function automatic out_word_t predict(in_word_t w);
		out_word_t r;
		int b, old;
		r.result_status = ST_OK;
		r.data_address = '0;
		case (w.func)
			FUNC_INIT: begin
				for (int i = 0; i < NBLK; i++)
					m_used[i] = 1'b0;
				m_count = 0;
				m_bump = m_base;
				m_left = m_bytes;
				if (carve(MinBlockDef) < 0)
					r.result_status = ST_NO_SPACE;
			end
			FUNC_ALLOC: begin
				b = grant(w.req_size);
				if (b < 0)
					r.result_status = ST_NO_SPACE;
				else
					r.data_address = data_addr(b);
			end
			FUNC_FREE: begin
				b = lookup(w.block_address);
				if (b < 0)
					r.result_status = ST_BAD_ARG;
				else
					m_used[b] = 1'b0;
			end
			default: begin
				old = lookup(w.block_address);
				if (old < 0) begin
					r.result_status = ST_BAD_ARG;
				end else begin
					b = grant(w.req_size);
					if (b < 0) begin
						r.result_status = ST_NO_SPACE;
					end else begin
						m_used[old] = 1'b0;
						r.data_address = data_addr(b);
					end
				end
			end
		endcase
		if (r.result_status == ST_OK && r.data_address != 0) begin
			live_addr.push_back(r.data_address);
			if (live_addr.size() > 40)
				void'(live_addr.pop_front());
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				result_q.push_back(predict(cmd));
				n_words++;
				n_func[cmd.func]++;
				gap = no_gap ? 0 : $urandom_range(0, 10);
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cmd <= pending_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (result_q.size() == 0) begin
				report("unexpected word", result.data_address, '0);
			end else begin
				out_word_t w;
				w = result_q.pop_front();
				n_status[w.result_status]++;
				if (result.result_status !== w.result_status)
					report("result_status", 32'(result.result_status),
						32'(w.result_status));
				if (result.data_address !== w.data_address)
					report("data_address", result.data_address, w.data_address);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", wdog);
			$display("tb_bump_block_allocator NOT OK");
			$finish;
		end
	end

	function automatic in_word_t mk(logic [1:0] f, logic [31:0] sz, logic [31:0] a);
		in_word_t w;
		w.func = f;
		w.req_size = sz;
		w.block_address = a;
		return w;
	endfunction

	function automatic logic [31:0] pick_addr();
		if (live_addr.size() > 0 && $urandom_range(0, 9) < 8)
			return live_addr[$urandom_range(0, live_addr.size() - 1)];
		return $urandom();
	endfunction

	function automatic in_word_t rand_word();
		int k;
		logic [31:0] sz;
		k = $urandom_range(0, 99);
		sz = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 200);
		if (k < 2)
			return mk(FUNC_INIT, $urandom(), $urandom());
		if (k < 50)
			return mk(FUNC_ALLOC, sz, $urandom());
		if (k < 78)
			return mk(FUNC_FREE, $urandom(), pick_addr());
		return mk(FUNC_REALLOC, sz, pick_addr());
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || result_q.size() > 0 || start || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_REGION_BASE)
			m_base = val;
		else
			m_bytes = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_region(logic [31:0] b, logic [31:0] n);
		drain();
		write_reg(CFG_REGION_BASE, b);
		write_reg(CFG_REGION_BYTES, n);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 8 == 0) begin
				while (pending_q.size() > 0)
					@(posedge clk);
				no_gap = ($urandom_range(0, 3) == 0);
			end
			pending_q.push_back(rand_word());
		end
	endtask

	logic [31:0] bases [7] = '{32'h0000_1000, 32'h0, 32'h0, 32'h0,
		32'hFFFF_FFF0, 32'h0000_0100, 32'h0};
	logic [31:0] sizes [7] = '{32'h0001_0000, 32'h0, 32'd62, 32'd63,
		32'hFFFF_FFFF, 32'd3000, 32'h0};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// use before init, then init on an empty region
		pending_q.push_back(mk(FUNC_ALLOC, 32'd5, 32'h0));
		pending_q.push_back(mk(FUNC_FREE, 32'h0, 32'h0));
		pending_q.push_back(mk(FUNC_REALLOC, 32'd8, 32'h10));
		pending_q.push_back(mk(FUNC_INIT, 32'h0, 32'h0));
		set_region(32'h0000_1000, 32'h0001_0000);
		pending_q.push_back(mk(FUNC_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_q.push_back(mk(FUNC_ALLOC, 32'd0, 32'h0));
		pending_q.push_back(mk(FUNC_ALLOC, 32'd1, 32'h0));
		pending_q.push_back(mk(FUNC_ALLOC, 32'd33, 32'h0));
		pending_q.push_back(mk(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0));
		drain();
		pending_q.push_back(mk(FUNC_FREE, 32'h0, live_addr[0]));
		pending_q.push_back(mk(FUNC_FREE, 32'h0, live_addr[0]));
		pending_q.push_back(mk(FUNC_FREE, 32'h0, 32'hDEAD_BEEF));
		pending_q.push_back(mk(FUNC_REALLOC, 32'd8, 32'h1234_5670));
		pending_q.push_back(mk(FUNC_REALLOC, 32'd40, live_addr[1]));
		pending_q.push_back(mk(FUNC_REALLOC, 32'hFFFF_FFF0, live_addr[2]));
		pending_q.push_back(mk(FUNC_ALLOC, 32'd20, 32'h0));
		// table full
		set_region(32'h0000_2000, 32'h0001_0000);
		pending_q.push_back(mk(FUNC_INIT, 32'h0, 32'h0));
		for (int i = 0; i < 70; i++)
			pending_q.push_back(mk(FUNC_ALLOC, $urandom_range(0, 48), 32'h0));
		run_random(30);
		for (int p = 0; p < 8; p++) begin
			if (p < 7)
				set_region(bases[p], sizes[p]);
			else
				set_region($urandom(), $urandom());
			live_addr.delete();
			pending_q.push_back(mk(FUNC_INIT, 32'h0, 32'h0));
			run_random(55);
		end
		drain();
		repeat (200) @(posedge clk);
		$display("words %0d: init %0d alloc %0d free %0d realloc %0d", n_words,
			n_func[FUNC_INIT], n_func[FUNC_ALLOC], n_func[FUNC_FREE], n_func[FUNC_REALLOC]);
		$display("results %0d: ok %0d no space %0d bad arg %0d, errors %0d", n_results,
			n_status[ST_OK], n_status[ST_NO_SPACE], n_status[ST_BAD_ARG], errors);
		if (errors == 0 && result_q.size() == 0)
			$display("tb_bump_block_allocator OK");
		else
			$display("tb_bump_block_allocator NOT OK");
		$finish;
	end

endmodule
